// ----- src/fsmk_pkg.sv -----
// shared types and constants of the flow shop makespan block
`timescale 1ns / 1ps
package fsmk_pkg;

	localparam int MAX_JOBS     = 32;
	localparam int JOB_BITS     = 5;
	localparam int MAX_MACHINES = 8;
	localparam int MACH_BITS    = 3;
	localparam int MCNT_BITS    = 4;
	localparam int TIME_BITS    = 8;
	localparam int FINISH_BITS  = 16;
	localparam int CHAIN_LAT    = 2 * MAX_MACHINES;
	localparam int FIFO_DEPTH   = 32;
	localparam int PTR_BITS     = 5;
	localparam int CNT_BITS     = 6;
	localparam int PADDR_BITS   = 3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	localparam logic [MCNT_BITS-1:0] MCNT_RESET = 4'd8;

	typedef struct packed {
		logic                   valid;
		logic                   op;
		logic [JOB_BITS-1:0]    job;
		logic [MACH_BITS-1:0]   mach;
		logic [TIME_BITS-1:0]   ptime;
		logic                   last;
		logic [FINISH_BITS-1:0] prev;
	} beat_t;

	typedef struct packed {
		logic                   is_last;
		logic [FINISH_BITS-1:0] finish;
	} result_t;

endpackage

// ----- src/flow_shop_makespan.sv -----
// top level of the permutation flow shop makespan evaluator
`timescale 1ns / 1ps
// Evaluates the makespan of a job permutation. Beats with operation 0 load one processing time
// (job, machine, time) into the table; beats with operation 1 schedule the next job and each
// return one result beat with the finish time on the last machine in use, is_makespan copying
// last_job. The row of finish times clears after a final job. A row of eight machine cells,
// each holding its own finish time and its own column of the time table, passes every beat
// along as a wavefront, so one beat is taken every cycle while in_ready is high; a schedule
// beat reaches the result queue through two register stages per cell (table read, then
// max-and-add). in_ready drops only when 32 schedule beats are in the row or waiting in the
// 32-entry result queue, which sets the sustained rate to one beat per cycle while the output
// side keeps taking results. machine_count is written over the APB port at address 0 and is
// clamped to 1..8; cells beyond the count pass the upstream finish time through unchanged.
module flow_shop_makespan (
	input  logic                               clk,
	input  logic                               arst_n,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fsmk_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [fsmk_pkg::JOB_BITS-1:0]      job_index,
	input  logic [fsmk_pkg::MACH_BITS-1:0]     machine_index,
	input  logic [fsmk_pkg::TIME_BITS-1:0]     proc_time,
	input  logic                               last_job,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fsmk_pkg::FINISH_BITS-1:0]   completion_time,
	output logic                               is_makespan
);

	// machine count register
	logic [fsmk_pkg::MCNT_BITS-1:0] mcount_q;
	logic [fsmk_pkg::MCNT_BITS-1:0] mcount_eff;
	logic                           cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcount_q <= fsmk_pkg::MCNT_RESET;
		end else if (cfg_we) begin
			mcount_q <= pwdata[fsmk_pkg::MCNT_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {{(32 - fsmk_pkg::MCNT_BITS){1'b0}}, mcount_q} : '0;

	// zero acts as one machine, anything above the row length as the full row
	always_comb begin
		priority if (mcount_q == '0) begin
			mcount_eff = fsmk_pkg::MCNT_BITS'(1);
		end else if (mcount_q > fsmk_pkg::MCNT_BITS'(fsmk_pkg::MAX_MACHINES)) begin
			mcount_eff = fsmk_pkg::MCNT_BITS'(fsmk_pkg::MAX_MACHINES);
		end else begin
			mcount_eff = mcount_q;
		end
	end

	// credits: schedule beats in the row plus results waiting in the queue
	logic [fsmk_pkg::CNT_BITS-1:0] credit_q;
	logic                          in_acc;
	logic                          sched_acc;
	logic                          out_acc;

	assign in_ready  = credit_q < fsmk_pkg::CNT_BITS'(fsmk_pkg::FIFO_DEPTH);
	assign in_acc    = in_valid && in_ready;
	assign sched_acc = in_acc && operation == fsmk_pkg::OP_SCHED;
	assign out_acc   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({sched_acc, out_acc})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// the cell row; the wavefront starts with an upstream finish of zero
	fsmk_pkg::beat_t chain [fsmk_pkg::MAX_MACHINES + 1];

	always_comb begin
		chain[0].valid = in_acc;
		chain[0].op    = operation;
		chain[0].job   = job_index;
		chain[0].mach  = machine_index;
		chain[0].ptime = proc_time;
		chain[0].last  = last_job;
		chain[0].prev  = '0;
	end

	for (genvar k = 0; k < fsmk_pkg::MAX_MACHINES; k++) begin : g_cell
		fsmk_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.mach_id  (fsmk_pkg::MACH_BITS'(k)),
			.active   (fsmk_pkg::MCNT_BITS'(k) < mcount_eff),
			.in_beat  (chain[k]),
			.out_beat (chain[k+1])
		);
	end

	// result queue
	logic              res_push;
	fsmk_pkg::result_t res_in;
	fsmk_pkg::result_t res_head;

	assign res_push       = chain[fsmk_pkg::MAX_MACHINES].valid &&
		chain[fsmk_pkg::MAX_MACHINES].op == fsmk_pkg::OP_SCHED;
	assign res_in.is_last = chain[fsmk_pkg::MAX_MACHINES].last;
	assign res_in.finish  = chain[fsmk_pkg::MAX_MACHINES].prev;

	fsmk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (out_acc),
		.not_empty (out_valid),
		.head      (res_head)
	);

	assign completion_time = res_head.finish;
	assign is_makespan     = res_head.is_last;

	// credits never exceed the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= fsmk_pkg::CNT_BITS'(fsmk_pkg::FIFO_DEPTH))
		else $error("credit count above queue depth");

	// a waiting result always holds a credit
	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> credit_q != '0)
		else $error("result shown without credit");

	// a schedule beat reaches the queue after the fixed row latency
	a_row_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sched_acc |-> ##(fsmk_pkg::CHAIN_LAT) res_push)
		else $error("schedule beat lost in the cell row");

	// results only leave the row for schedule beats that were counted
	a_push_credit: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> credit_q != '0)
		else $error("result pushed without credit");

endmodule

// ----- src/fsmk_cell.sv -----
// one machine cell of the systolic finish-time row
`timescale 1ns / 1ps
module fsmk_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fsmk_pkg::MACH_BITS-1:0]  mach_id,
	input  logic                            active,
	input  fsmk_pkg::beat_t                 in_beat,
	output fsmk_pkg::beat_t                 out_beat
);

	// this machine's column of the time table
	logic [fsmk_pkg::TIME_BITS-1:0] times_q [fsmk_pkg::MAX_JOBS];

	fsmk_pkg::beat_t                   beat_s1;
	logic [fsmk_pkg::TIME_BITS-1:0]    rd_s1;
	logic [fsmk_pkg::FINISH_BITS-1:0]  finish_q;
	fsmk_pkg::beat_t                   beat_s2;

	logic [fsmk_pkg::FINISH_BITS-1:0]  base;
	logic [fsmk_pkg::FINISH_BITS:0]    sum;
	logic [fsmk_pkg::FINISH_BITS-1:0]  done;
	logic                              sched_s1;

	// stage 1: table read, local table write
	always_ff @(posedge clk) begin
		if (in_beat.valid) begin
			rd_s1 <= times_q[in_beat.job];
			if (in_beat.op == fsmk_pkg::OP_WRITE && in_beat.mach == mach_id) begin
				times_q[in_beat.job] <= in_beat.ptime;
			end
		end
	end

	// only the valid bit is reset, the payload just follows along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1.valid <= 1'b0;
		end else begin
			beat_s1.valid <= in_beat.valid;
			beat_s1.op    <= in_beat.op;
			beat_s1.job   <= in_beat.job;
			beat_s1.mach  <= in_beat.mach;
			beat_s1.ptime <= in_beat.ptime;
			beat_s1.last  <= in_beat.last;
			beat_s1.prev  <= in_beat.prev;
		end
	end

	// stage 2: max of own and upstream finish, saturating add
	assign sched_s1 = beat_s1.valid && beat_s1.op == fsmk_pkg::OP_SCHED;
	assign base     = (beat_s1.prev > finish_q) ? beat_s1.prev : finish_q;
	assign sum      = {1'b0, base} + {{(fsmk_pkg::FINISH_BITS + 1 - fsmk_pkg::TIME_BITS){1'b0}},
		rd_s1};
	assign done     = sum[fsmk_pkg::FINISH_BITS] ? '1 : sum[fsmk_pkg::FINISH_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_q      <= '0;
			beat_s2.valid <= 1'b0;
		end else begin
			beat_s2.valid <= beat_s1.valid;
			beat_s2.op    <= beat_s1.op;
			beat_s2.job   <= beat_s1.job;
			beat_s2.mach  <= beat_s1.mach;
			beat_s2.ptime <= beat_s1.ptime;
			beat_s2.last  <= beat_s1.last;
			beat_s2.prev  <= (sched_s1 && active) ? done : beat_s1.prev;
			if (sched_s1) begin
				if (beat_s1.last) begin
					finish_q <= '0;
				end else if (active) begin
					finish_q <= done;
				end
			end
		end
	end

	assign out_beat = beat_s2;

endmodule

// ----- src/fsmk_fifo.sv -----
// result queue at the end of the cell row
`timescale 1ns / 1ps
module fsmk_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fsmk_pkg::result_t   push_data,
	input  logic                pop,
	output logic                not_empty,
	output fsmk_pkg::result_t   head
);

	fsmk_pkg::result_t                mem_q [fsmk_pkg::FIFO_DEPTH];
	logic [fsmk_pkg::PTR_BITS-1:0]    wr_ptr_q;
	logic [fsmk_pkg::PTR_BITS-1:0]    rd_ptr_q;
	logic [fsmk_pkg::CNT_BITS-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

endmodule
